@@ rtl/ttt_pkg.sv @@
// ----------------------------------------------------------------------------
// ttt_pkg
// Types and constants shared by the two-tier transposition table.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int CFG_W              = 13;
  localparam int MAX_SLOTS_DEF      = 4096;
  localparam logic [CFG_W-1:0] SLOTS_RESET = 13'd4093;
  localparam int SIG_W              = 64;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  localparam logic [1:0] FLAG_UNKNOWN = 2'd0;
  localparam logic [1:0] FLAG_ALPHA   = 2'd1;
  localparam logic [1:0] FLAG_BETA    = 2'd2;
  localparam logic [1:0] FLAG_EXACT   = 2'd3;

  typedef struct packed {
    logic                kind;
    logic                white_to_move;
    logic [63:0]         signature;
    logic [15:0]         depth;
    logic signed [31:0]  alpha;
    logic signed [31:0]  beta;
    logic [29:0]         move;
    logic signed [15:0]  score;
    logic [1:0]          bound_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  new_alpha;
    logic signed [31:0]  new_beta;
    logic [29:0]         best_move;
  } out_item_t;

  typedef struct packed {
    logic [63:0]         sig;
    logic [29:0]         move;
    logic [1:0]          flag;
    logic signed [15:0]  score;
    logic [15:0]         depth;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_RDP,
    S_RDA,
    S_EVAL,
    S_RESP,
    S_WR2
  } state_t;

endpackage

@@ rtl/ttt_ram.sv @@
// ----------------------------------------------------------------------------
// ttt_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/two_tier_transposition_table.sv @@
// ----------------------------------------------------------------------------
// two_tier_transposition_table
// Hash table of search results with a depth-preferred and an always-replace
// region per side to move.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole entry memory to zero, one entry a
// cycle, all 6*MAX_PRIMARY_SLOTS entries (24576 at the default), with busy
// high; the slot count register can be written meanwhile. An item is taken
// when start is high and busy is low. The slot indexes come from a bit-serial
// divider that runs over all 64 signature bits, then the table is read and
// updated: a probe holds busy until its result shows on out_data with
// out_valid high for one cycle, in the cycle busy drops. A store holds busy
// until its writes are done and gives no result. Results cannot be held off.
module two_tier_transposition_table
  import ttt_pkg::*;
#(
  parameter int MAX_PRIMARY_SLOTS = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = 6 * MAX_PRIMARY_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_PRIMARY_SLOTS + 1);
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] slots_r;
  in_item_t         item_r;
  logic [NW-1:0]    n_r;
  logic [NW-1:0]    rem_r;
  logic             qlsb_r;
  logic [SIG_W-1:0] sig_sh_r;
  logic [5:0]       cnt_r;
  logic [AW-1:0]    pa_r, aa_r;
  logic [AW-1:0]    clr_r;
  entry_t           hit_r, ent_r;
  logic             match_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             accept;
  logic [CW-1:0]    cfg_ext, n_c;
  logic [NW:0]      trial;
  logic             ge;
  logic [AW-1:0]    n_a, r_a, r2_a;
  entry_t           fresh, rd_ent, sel_ent;
  logic             promote;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{(32-CFG_W){1'b0}}, slots_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      slots_r <= pwdata[CFG_W-1:0];
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // clamp slot count into [1, MAX_PRIMARY_SLOTS]
  always_comb begin
    cfg_ext = CW'(slots_r);
    if (cfg_ext == '0) begin
      n_c = CW'(1);
    end else if (cfg_ext > CW'(MAX_PRIMARY_SLOTS)) begin
      n_c = CW'(MAX_PRIMARY_SLOTS);
    end else begin
      n_c = cfg_ext;
    end
  end

  // one restoring step; the last quotient bit picks the always slot
  assign trial = {rem_r, sig_sh_r[SIG_W-1]};
  assign ge    = trial >= {1'b0, n_r};

  assign n_a  = AW'(n_r);
  assign r_a  = AW'(rem_r);
  assign r2_a = r_a + (qlsb_r ? n_a : '0);

  assign fresh.sig   = item_r.signature;
  assign fresh.move  = item_r.move;
  assign fresh.flag  = item_r.bound_flag;
  assign fresh.score = item_r.score;
  assign fresh.depth = item_r.depth;

  assign rd_ent  = entry_t'(ram_rdata);
  assign sel_ent = (hit_r.sig != '0 && hit_r.sig != item_r.signature) ? rd_ent : hit_r;
  assign promote = (hit_r.depth < item_r.depth) ||
                   (hit_r.depth == item_r.depth && hit_r.flag <= item_r.bound_flag);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_RDP;
      S_RDP:   state_nxt = S_RDA;
      S_RDA:   state_nxt = S_EVAL;
      S_EVAL: begin
        if (item_r.kind == KIND_PROBE) begin
          state_nxt = S_RESP;
        end else if (hit_r.sig != '0 && promote) begin
          state_nxt = S_WR2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP:  state_nxt = S_IDLE;
      S_WR2:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pa_r;
    ram_wdata = ENTRY_W'(fresh);
    ram_raddr = pa_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_RDA: ram_raddr = aa_r;
      S_EVAL: begin
        if (item_r.kind == KIND_STORE) begin
          ram_we = 1'b1;
          if (hit_r.sig != '0) begin
            ram_waddr = aa_r;
            if (promote) ram_wdata = ENTRY_W'(hit_r);
          end
        end
      end
      S_WR2: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RESP);
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_data;
      n_r      <= n_c[NW-1:0];
      rem_r    <= '0;
      sig_sh_r <= in_data.signature;
      cnt_r    <= 6'd63;
    end
    if (state_r == S_DIV) begin
      rem_r    <= ge ? NW'(trial - {1'b0, n_r}) : trial[NW-1:0];
      qlsb_r   <= ge;
      sig_sh_r <= {sig_sh_r[SIG_W-2:0], 1'b0};
      cnt_r    <= cnt_r - 6'd1;
    end
    if (state_r == S_ADDR) begin
      pa_r <= item_r.white_to_move ? r_a : (n_a << 1) + n_a + r_a;
      aa_r <= item_r.white_to_move ? n_a + r2_a : (n_a << 2) + r2_a;
    end
    if (state_r == S_RDA) hit_r <= rd_ent;
    if (state_r == S_EVAL) begin
      ent_r   <= sel_ent;
      match_r <= (sel_ent.sig == item_r.signature);
    end
  end

  // probe verdict
  always_ff @(posedge clk) begin
    if (state_r == S_RESP) begin
      out_data_r.status    <= FLAG_UNKNOWN;
      out_data_r.new_alpha <= item_r.alpha;
      out_data_r.new_beta  <= item_r.beta;
      out_data_r.best_move <= '0;
      if (match_r) begin
        out_data_r.best_move <= ent_r.move;
        if (ent_r.depth >= item_r.depth) begin
          if (ent_r.flag == FLAG_EXACT) begin
            out_data_r.new_alpha <= 32'(ent_r.score);
            out_data_r.status    <= FLAG_EXACT;
          end else if (ent_r.flag == FLAG_ALPHA && 32'(ent_r.score) >= item_r.beta) begin
            out_data_r.new_alpha <= 32'(ent_r.score);
            out_data_r.status    <= FLAG_ALPHA;
          end else if (ent_r.flag == FLAG_BETA && 32'(ent_r.score) <= item_r.alpha) begin
            out_data_r.new_beta <= 32'(ent_r.score);
            out_data_r.status   <= FLAG_BETA;
          end else if (ent_r.flag == FLAG_BETA && 32'(ent_r.score) < item_r.beta) begin
            out_data_r.new_beta <= 32'(ent_r.score);
          end else if (ent_r.flag == FLAG_ALPHA && 32'(ent_r.score) > item_r.alpha) begin
            out_data_r.new_alpha <= 32'(ent_r.score);
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ttt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < n_r))
    else $error("divider remainder out of range");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < AW'(DEPTH)))
    else $error("table write beyond the store");

endmodule

@@ bench/two_tier_transposition_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_tier_transposition_table_tb
// Drives probes and stores with random idling, keeps a shadow hash table with
// the same replacement rules, and checks every probe verdict field by field.
// ----------------------------------------------------------------------------
module two_tier_transposition_table_tb
  import ttt_pkg::*;
();

  localparam int MAXN = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_tier_transposition_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  entry_t      shadow_table [6*MAXN];
  logic [12:0] slot_reg;
  in_item_t    pending_items [$];
  out_item_t   expected_verdicts [$];
  int          mismatch_count = 0;
  int          quiet_drive = 0;
  logic        driver_hold = 1'b0;

  task automatic report(input string what);
    mismatch_count++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  // updates the shadow table for stores; returns 1 with a verdict for probes
  function automatic bit apply_item(input in_item_t it, output out_item_t v);
    longint unsigned n;
    int              pi, ai;
    entry_t          fresh, e;
    logic signed [31:0] a, b, s;
    if (slot_reg == '0) begin
      n = 64'd1;
    end else if (slot_reg > 13'(MAXN)) begin
      n = 64'(MAXN);
    end else begin
      n = 64'(slot_reg);
    end
    pi = int'((it.white_to_move ? 64'd0 : 64'd3 * n) + it.signature % n);
    ai = int'((it.white_to_move ? n : 64'd4 * n) + it.signature % (64'd2 * n));
    v = '0;
    if (it.kind == KIND_STORE) begin
      fresh = '{sig: it.signature, move: it.move, flag: it.bound_flag,
                score: it.score, depth: it.depth};
      if (shadow_table[pi].sig != 0) begin
        if (shadow_table[pi].depth < it.depth || (shadow_table[pi].depth == it.depth
            && shadow_table[pi].flag <= it.bound_flag)) begin
          shadow_table[ai] = shadow_table[pi];
          shadow_table[pi] = fresh;
        end else begin
          shadow_table[ai] = fresh;
        end
      end else begin
        shadow_table[pi] = fresh;
      end
      return 0;
    end
    e = shadow_table[pi];
    if (e.sig != 0 && e.sig != it.signature) e = shadow_table[ai];
    a = it.alpha;
    b = it.beta;
    v.status = FLAG_UNKNOWN;
    if (e.sig == it.signature) begin
      s = e.score;
      v.best_move = e.move;
      if (e.depth >= it.depth) begin
        if (e.flag == FLAG_EXACT) begin
          a = s; v.status = FLAG_EXACT;
        end else if (e.flag == FLAG_ALPHA && s >= b) begin
          a = s; v.status = FLAG_ALPHA;
        end else if (e.flag == FLAG_BETA && s <= a) begin
          b = s; v.status = FLAG_BETA;
        end else if (e.flag == FLAG_BETA && s < b) begin
          b = s;
        end else if (e.flag == FLAG_ALPHA && s > a) begin
          a = s;
        end
      end
    end
    v.new_alpha = a;
    v.new_beta = b;
    return 1;
  endfunction

  // driver: idles at random except during a quiet stretch
  always @(posedge clk) begin
    out_item_t v;
    if (rst_n) begin
      if (start && !busy) begin
        if (apply_item(in_data, v)) expected_verdicts.push_back(v);
        quiet_drive <= quiet_drive + 1;
      end
      if (start && !busy) begin
        if (pending_items.size() > 0 && !driver_hold
            && (quiet_drive inside {[200:320]} || $urandom_range(99) >= 24)) begin
          in_data <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_items.size() > 0 && !driver_hold
                   && (quiet_drive inside {[200:320]} || $urandom_range(99) >= 24)) begin
        in_data <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t x;
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        report("result with nothing expected");
      end else begin
        x = expected_verdicts.pop_front();
        if (out_data.status !== x.status)
          report($sformatf("status %0d exp %0d", out_data.status, x.status));
        if (out_data.new_alpha !== x.new_alpha)
          report($sformatf("new_alpha %0d exp %0d", out_data.new_alpha, x.new_alpha));
        if (out_data.new_beta !== x.new_beta)
          report($sformatf("new_beta %0d exp %0d", out_data.new_beta, x.new_beta));
        if (out_data.best_move !== x.best_move)
          report($sformatf("best_move %h exp %h", out_data.best_move, x.best_move));
      end
    end
  end

  task automatic write_slots(input logic [12:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {19'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    slot_reg = val;
  endtask

  // waits for the block to drain; stores leave no result so wait out busy too
  task automatic drain();
    while (pending_items.size() > 0 || start || busy || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  logic [63:0] sig_pool [16];

  function automatic in_item_t make_item(input bit store, input logic [63:0] sig);
    in_item_t it;
    it.kind = store ? KIND_STORE : KIND_PROBE;
    it.white_to_move = 1'($urandom_range(1));
    it.signature = sig;
    it.depth = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    it.alpha = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(600)) - 300;
    it.beta = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(600)) - 100;
    it.move = 30'($urandom);
    it.score = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : 16'($signed($urandom_range(800)) - 400);
    it.bound_flag = 2'($urandom_range(3));
    return it;
  endfunction

  task automatic random_phase(input int count);
    in_item_t it;
    for (int i = 0; i < 16; i++) sig_pool[i] = {$urandom, $urandom};
    sig_pool[0] = 64'd0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0)
        it = make_item(1'($urandom_range(1)), {$urandom, $urandom});
      else
        it = make_item($urandom_range(99) < 45, sig_pool[$urandom_range(15)]);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    for (int i = 0; i < 6*MAXN; i++) shadow_table[i] = '0;
    slot_reg = SLOTS_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_slots(13'd7);
    // directed: extremes, every flag, signature zero
    for (int f = 0; f < 4; f++) begin
      it = make_item(1'b1, 64'hFFFF_FFFF_FFFF_FFF0 + 64'(f));
      it.bound_flag = 2'(f); it.depth = 16'hFFFF;
      it.score = (f[0]) ? 16'sh7FFF : 16'sh8000;
      it.move = 30'h3FFFFFFF; it.white_to_move = f[1];
      pending_items.push_back(it);
      it.kind = KIND_PROBE; it.depth = 16'd0;
      it.alpha = 32'sh8000_0000; it.beta = 32'sh7FFF_FFFF;
      pending_items.push_back(it);
      it.alpha = 32'sh7FFF_FFFF; it.beta = 32'sh8000_0000;
      pending_items.push_back(it);
    end
    it = make_item(1'b0, 64'd0); pending_items.push_back(it);
    it = make_item(1'b1, 64'd0); pending_items.push_back(it);
    it = make_item(1'b0, 64'd0); pending_items.push_back(it);
    it = make_item(1'b0, 64'h1234); it.depth = 16'hFFFF; pending_items.push_back(it);
    drain();
    write_slots(13'd1);
    random_phase(150);
    drain();
    write_slots(13'd0);
    random_phase(100);
    // hold the sender until everything queued so far has come back
    while (pending_items.size() > 0) @(posedge clk);
    driver_hold = 1'b1;
    while (start || busy || expected_verdicts.size() > 0) @(posedge clk);
    driver_hold = 1'b0;
    random_phase(100);
    drain();
    write_slots(13'd8191);
    random_phase(150);
    drain();
    write_slots(13'd4096);
    random_phase(100);
    drain();
    write_slots(13'd13);
    random_phase(100);
    drain();
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ttt_pkg.sv
rtl/ttt_ram.sv
rtl/two_tier_transposition_table.sv
bench/two_tier_transposition_table_tb.sv
